[sv/dts_pkg.sv]
package dts_pkg;

  localparam int unsigned CHANNELS = 32;
  localparam int unsigned CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int unsigned CH_W     = 5;
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned VAL_W    = 8;
  localparam int unsigned DB_W     = 10;
  localparam int unsigned CFG_W    = 10;

  // x/6 for x < 1024 as (x * 683) >> 12
  localparam int unsigned DIV6_MUL   = 683;
  localparam int unsigned DIV6_SHIFT = 12;
  localparam int unsigned DIV6_PW    = 20;

  localparam logic [VAL_W-1:0] SMOOTH_RST = 8'd230;
  localparam logic [DB_W-1:0]  DB_RST     = 10'd4;

  typedef logic [CH_AW-1:0] ch_addr_t;

  typedef enum logic [0:0] {
    REG_SMOOTH   = 1'b0,
    REG_DEADBAND = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EX1  = 2'd1,
    S_EX2  = 2'd2,
    S_WB   = 2'd3
  } state_e;

  typedef struct packed {
    logic [VAL_W-1:0] s1;
    logic [VAL_W-1:0] s2;
    logic [VAL_W-1:0] lr;
  } entry_t;

  typedef struct packed {
    logic load;
    logic ex1;
    logic ex2;
    logic wb;
  } upd_ctl_t;

  // floor((x*(256-f) + old*f) / 256)
  function automatic logic [VAL_W-1:0] ema(logic [VAL_W-1:0] x, logic [VAL_W-1:0] old,
                                           logic [VAL_W-1:0] f);
    logic [15:0] acc;
    acc = 16'(x) * (16'd256 - 16'(f)) + 16'(old) * 16'(f);
    return acc[15:8];
  endfunction

endpackage

[sv/dts_state_mem.sv]
module dts_state_mem (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  dts_pkg::ch_addr_t rd_addr_i,
  output dts_pkg::entry_t   rd_entry_o,
  input  logic              wr_en_i,
  input  dts_pkg::ch_addr_t wr_addr_i,
  input  dts_pkg::entry_t   wr_entry_i
);

  dts_pkg::entry_t                   mem_q [dts_pkg::CHANNELS];
  dts_pkg::entry_t                   rdata_q;
  logic [dts_pkg::CHANNELS-1:0]      vld_q;
  logic                              rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_entry_o = rd_vld_q ? rdata_q : '0;

endmodule

[sv/dts_update.sv]
module dts_update (
  input  logic                               clk_i,
  input  dts_pkg::upd_ctl_t                  ctl_i,
  input  logic [dts_pkg::SAMPLE_W-1:0]       sample_i,
  input  logic                               ack_i,
  input  logic                               in_range_i,
  input  dts_pkg::entry_t                    entry_i,
  input  logic [dts_pkg::VAL_W-1:0]          smooth_i,
  input  logic [dts_pkg::DB_W-1:0]           deadband_i,
  output logic                               wr_en_o,
  output dts_pkg::entry_t                    wr_entry_o,
  output logic [dts_pkg::VAL_W-1:0]          smoothed_o,
  output logic                               changed_o
);

  logic [dts_pkg::SAMPLE_W-1:0] raw_q;
  logic [dts_pkg::VAL_W-1:0]    quot_q;
  logic                         ack_q;
  logic                         in_range_q;
  logic                         upd_q;
  logic [dts_pkg::VAL_W-1:0]    n1_q;
  logic [dts_pkg::VAL_W-1:0]    n2_q;

  logic [dts_pkg::DIV6_PW-1:0]  div_prod;
  logic [dts_pkg::SAMPLE_W:0]   raw_x;
  logic [dts_pkg::SAMPLE_W:0]   s1_x;
  logic [dts_pkg::SAMPLE_W:0]   db_x;
  logic                         upd;
  logic [dts_pkg::VAL_W-1:0]    sm;

  assign div_prod = dts_pkg::DIV6_PW'(sample_i) * dts_pkg::DIV6_PW'(dts_pkg::DIV6_MUL);

  assign raw_x = (dts_pkg::SAMPLE_W + 1)'(raw_q);
  assign s1_x  = (dts_pkg::SAMPLE_W + 1)'(entry_i.s1);
  assign db_x  = (dts_pkg::SAMPLE_W + 1)'(deadband_i);
  // unscaled raw sample against scaled stage one, outside the band on either side
  assign upd   = (raw_x > s1_x + db_x) || (raw_x + db_x < s1_x);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      raw_q      <= sample_i;
      quot_q     <= div_prod[dts_pkg::DIV6_SHIFT +: dts_pkg::VAL_W];
      ack_q      <= ack_i;
      in_range_q <= in_range_i;
    end
    if (ctl_i.ex1) begin
      upd_q <= upd;
      n1_q  <= dts_pkg::ema(quot_q, entry_i.s1, smooth_i);
    end
    if (ctl_i.ex2) begin
      n2_q <= dts_pkg::ema(n1_q, entry_i.s2, smooth_i);
    end
  end

  always_comb begin
    sm            = upd_q ? n2_q : entry_i.s2;
    wr_entry_o.s1 = upd_q ? n1_q : entry_i.s1;
    wr_entry_o.s2 = sm;
    wr_entry_o.lr = ack_q ? sm : entry_i.lr;
    wr_en_o       = ctl_i.wb & in_range_q;
    smoothed_o    = in_range_q ? sm : '0;
    changed_o     = in_range_q && (sm != entry_i.lr);
  end

endmodule

[sv/deadband_two_stage_smoother_top.sv]
// Two-stage exponential smoother with deadband, 32 channels. For each accepted sample, the
// channel's state word is read from the state memory on acceptance, the deadband test and
// stage one follow, then stage two, then writeback and the result register.
// The per-channel read-modify-write of that single memory paces the block, so a new sample is
// taken the cycle after writeback at the earliest; none is accepted while one is in flight.
// A result may wait in the output register while the next sample is accepted. Per-channel
// valid flops clear the state at reset at once; there is no clearing pass. Write
// smooth_factor and deadband only while no sample is in flight.
module deadband_two_stage_smoother_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [dts_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [dts_pkg::CH_W-1:0]      channel_i,
  input  logic [dts_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                          acknowledge_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dts_pkg::CH_W-1:0]      out_channel_o,
  output logic [dts_pkg::VAL_W-1:0]     smoothed_o,
  output logic                          changed_o
);

  dts_pkg::state_e              state_q, state_d;
  logic [dts_pkg::VAL_W-1:0]    smooth_q;
  logic [dts_pkg::DB_W-1:0]     db_q;
  logic [dts_pkg::CH_W-1:0]     ch_q;
  dts_pkg::ch_addr_t            addr_q;
  logic                         out_valid_q, out_valid_d;
  logic [dts_pkg::CH_W-1:0]     out_ch_q;
  logic [dts_pkg::VAL_W-1:0]    out_sm_q;
  logic                         out_chg_q;

  dts_pkg::upd_ctl_t            ctl;
  logic                         accept;
  logic                         in_range;
  dts_pkg::entry_t              rd_entry;
  dts_pkg::entry_t              wr_entry;
  logic                         wr_en;
  logic [dts_pkg::VAL_W-1:0]    upd_sm;
  logic                         upd_chg;

  assign accept   = in_valid_i & in_ready_o;
  assign in_range = (32'(channel_i) < dts_pkg::CHANNELS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q <= dts_pkg::SMOOTH_RST;
      db_q     <= dts_pkg::DB_RST;
    end else if (cfg_we_i) begin
      unique case (dts_pkg::reg_idx_e'(cfg_idx_i))
        dts_pkg::REG_SMOOTH:   smooth_q <= cfg_wdata_i[dts_pkg::VAL_W-1:0];
        dts_pkg::REG_DEADBAND: db_q     <= cfg_wdata_i[dts_pkg::DB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dts_pkg::S_IDLE: if (accept) state_d = dts_pkg::S_EX1;
      dts_pkg::S_EX1:  state_d = dts_pkg::S_EX2;
      dts_pkg::S_EX2:  state_d = dts_pkg::S_WB;
      dts_pkg::S_WB:   if (!out_valid_q || out_ready_i) state_d = dts_pkg::S_IDLE;
      default:         state_d = dts_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == dts_pkg::S_IDLE);
    ctl.load   = accept;
    ctl.ex1    = (state_q == dts_pkg::S_EX1);
    ctl.ex2    = (state_q == dts_pkg::S_EX2);
    // hold writeback until the output register is free
    ctl.wb     = (state_q == dts_pkg::S_WB) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl.wb) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dts_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q   <= channel_i;
      addr_q <= dts_pkg::ch_addr_t'(channel_i);
    end
    if (ctl.wb) begin
      out_ch_q  <= ch_q;
      out_sm_q  <= upd_sm;
      out_chg_q <= upd_chg;
    end
  end

  dts_state_mem u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_addr_i  (dts_pkg::ch_addr_t'(channel_i)),
    .rd_entry_o (rd_entry),
    .wr_en_i    (wr_en),
    .wr_addr_i  (addr_q),
    .wr_entry_i (wr_entry)
  );

  dts_update u_upd (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .sample_i   (sample_i),
    .ack_i      (acknowledge_i),
    .in_range_i (in_range),
    .entry_i    (rd_entry),
    .smooth_i   (smooth_q),
    .deadband_i (db_q),
    .wr_en_o    (wr_en),
    .wr_entry_o (wr_entry),
    .smoothed_o (upd_sm),
    .changed_o  (upd_chg)
  );

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_ch_q;
  assign smoothed_o    = out_sm_q;
  assign changed_o     = out_chg_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == dts_pkg::S_EX1)
    else $error("accepted transaction did not start processing");

  a_write_in_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == dts_pkg::S_WB) && (!out_valid_q || out_ready_i))
    else $error("state write outside writeback");

  a_result_from_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == dts_pkg::S_WB)
    else $error("result appeared without writeback");

  a_wb_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dts_pkg::S_WB) && out_valid_q && !out_ready_i |=> state_q == dts_pkg::S_WB)
    else $error("writeback left while output register was full");

endmodule
